[rtl/sld_pkg.sv]
// ----------------------------------------------------------------------------
// sld_pkg: shared types and constants for the lagged-Fibonacci descrambler
// lag table geometry, modulus, configuration register codes and sequencer states
// ----------------------------------------------------------------------------
package sld_pkg;

  localparam int unsigned DEFAULT_RESEED_INTERVAL = 16;

  localparam int unsigned VAL_W  = 30;
  localparam int unsigned ADDR_W = 6;
  localparam int unsigned KEY_BYTES = 16;

  localparam logic [VAL_W-1:0]  LFG_MODULUS = 30'd1000000000;
  localparam logic [ADDR_W-1:0] LAG_LEN     = 6'd55;
  localparam logic [ADDR_W-1:0] FILL_STEP   = 6'd21;
  localparam logic [ADDR_W-1:0] FILL_STEPS  = 6'd54;
  localparam logic [ADDR_W-1:0] MIX_SPLIT   = 6'd25;
  localparam logic [ADDR_W-1:0] MIX_FAR     = 6'd31;
  localparam logic [ADDR_W-1:0] MIX_NEAR    = 6'd24;
  localparam logic [2:0]        RESEED_PASSES = 3'd4;

  localparam logic [31:0] KEY_WORD0_RST = 32'd3432986453;
  localparam logic [31:0] KEY_WORD1_RST = 32'd2575149027;
  localparam logic [31:0] KEY_WORD2_RST = 32'd3485182685;
  localparam logic [31:0] KEY_WORD3_RST = 32'd390293500;

  typedef enum logic [2:0] {
    CFG_KEY_WORD0 = 3'd0,
    CFG_KEY_WORD1 = 3'd1,
    CFG_KEY_WORD2 = 3'd2,
    CFG_KEY_WORD3 = 3'd3,
    CFG_DIRECTION = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_MIX,
    ST_KEY_RD,
    ST_DELIVER
  } state_e;

  // a - b modulo 1e9, both operands below the modulus
  function automatic logic [VAL_W-1:0] mod_sub(input logic [VAL_W-1:0] a,
                                               input logic [VAL_W-1:0] b);
    logic [VAL_W:0] diff;
    diff = {1'b0, a} - {1'b0, b};
    if (diff[VAL_W]) begin
      diff = diff + {1'b0, LFG_MODULUS};
    end
    return diff[VAL_W-1:0];
  endfunction

endpackage

[rtl/subtractive_lfg_byte_descrambler.sv]
// ----------------------------------------------------------------------------
// subtractive_lfg_byte_descrambler: keystream byte descrambler / scrambler
// ran3-style subtractive lagged-Fibonacci generator (mod 1e9), 55-entry lag table
// ----------------------------------------------------------------------------
// Each accepted byte gets the low 8 bits of the next lag-table entry subtracted
// (direction 0) or added (direction 1), modulo 256. Every RESEED_INTERVAL bytes
// the table is rebuilt from the next key byte (a 54-step fill walking by 21,
// then four mix passes); restart on a byte sends the count back to key byte 0.
// All table arithmetic runs through one mod-1e9 subtractor, fed from the
// cur/prev registers in fill and from a two-read, one-write lag-table memory
// in mix, one table update per cycle. An ordinary byte goes through ST_KEY_RD
// and ST_DELIVER to the output register; a byte that wraps the read index
// first runs a 55-step mix pass. in_ready_o is low while a byte is worked on;
// a finished result sits in the output register and the next byte may be
// taken meanwhile. The user must write key and direction through the cfg port
// only while idle; the block does not enforce it. The table needs no clearing
// after reset since the first byte always reseeds.
// ----------------------------------------------------------------------------
module subtractive_lfg_byte_descrambler #(
  parameter int unsigned RESEED_INTERVAL = sld_pkg::DEFAULT_RESEED_INTERVAL
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  // byte input channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        restart_i,
  // byte output channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  result_byte_o
);

  localparam int unsigned PHASE_W = (RESEED_INTERVAL > 1) ? $clog2(RESEED_INTERVAL) : 1;
  localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(RESEED_INTERVAL - 1);
  localparam int unsigned VW = sld_pkg::VAL_W;
  localparam int unsigned AW = sld_pkg::ADDR_W;
  localparam int unsigned DEPTH = 56;

  // sequencer
  sld_pkg::state_e state_q, state_d;

  // configuration registers
  logic [31:0] key_word0_q, key_word1_q, key_word2_q, key_word3_q;
  logic        direction_q;

  // stream position: byte_count = key_idx * RESEED_INTERVAL + phase
  logic [PHASE_W-1:0] phase_q, phase_d;
  logic [3:0]         key_idx_q, key_idx_d;
  logic [AW-1:0]      read_index_q, read_index_d;

  // working registers
  logic [7:0]    data_q, data_d;
  logic [AW-1:0] fill_cnt_q, fill_cnt_d;
  logic [AW-1:0] slot_q, slot_d;
  logic [VW-1:0] prev_q, prev_d;
  logic [VW-1:0] cur_q, cur_d;
  logic [AW-1:0] k_q, k_d;
  logic [2:0]    passes_q, passes_d;

  // mix write-back stage
  logic          wr_pend_q, wr_pend_d;
  logic [AW-1:0] wr_addr_q, wr_addr_d;

  // lag table memory
  logic [VW-1:0] lag_mem [DEPTH];
  logic [VW-1:0] rd_a_q, rd_b_q;
  logic [AW-1:0] raddr_a, raddr_b;
  logic          mem_we;
  logic [AW-1:0] waddr;
  logic [VW-1:0] wdata;

  // output register
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_data_q, out_data_d;

  // shared mod-1e9 subtractor
  logic [VW-1:0] sub_a, sub_b, sub_res;

  logic               in_xfer;
  logic               out_free;
  logic [PHASE_W-1:0] cur_phase;
  logic [3:0]         cur_key;
  logic [31:0]        key_word;
  logic [7:0]         seed;
  logic [AW-1:0]      partner;
  logic [AW:0]        slot_sum;
  logic [7:0]         ks;

  assign in_ready_o    = (state_q == sld_pkg::ST_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign out_valid_o   = out_valid_q;
  assign result_byte_o = out_data_q;

  assign in_xfer  = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  // restart drops the count back to the start of the key
  assign cur_phase = restart_i ? '0 : phase_q;
  assign cur_key   = restart_i ? 4'd0 : key_idx_q;

  always_comb begin
    case (cur_key[3:2])
      2'd0:    key_word = key_word0_q;
      2'd1:    key_word = key_word1_q;
      2'd2:    key_word = key_word2_q;
      default: key_word = key_word3_q;
    endcase
  end

  assign seed = 8'(key_word >> {cur_key[1:0], 3'b000});

  // mix partner: first 24 entries pull from 31 ahead, the rest from 24 behind
  assign partner = (k_q < sld_pkg::MIX_SPLIT) ? (k_q + sld_pkg::MIX_FAR)
                                              : (k_q - sld_pkg::MIX_NEAR);

  // fill slot walks by 21 modulo 55
  assign slot_sum = {1'b0, slot_q} + {1'b0, sld_pkg::FILL_STEP};

  assign sub_res = sld_pkg::mod_sub(sub_a, sub_b);
  assign ks      = rd_a_q[7:0];

  always_comb begin
    state_d      = state_q;
    phase_d      = phase_q;
    key_idx_d    = key_idx_q;
    read_index_d = read_index_q;
    data_d       = data_q;
    fill_cnt_d   = fill_cnt_q;
    slot_d       = slot_q;
    prev_d       = prev_q;
    cur_d        = cur_q;
    k_d          = k_q;
    passes_d     = passes_q;
    wr_pend_d    = 1'b0;
    wr_addr_d    = wr_addr_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_data_d   = out_data_q;
    sub_a        = rd_a_q;
    sub_b        = rd_b_q;
    raddr_a      = read_index_q;
    raddr_b      = read_index_q;
    mem_we       = 1'b0;
    waddr        = wr_addr_q;
    wdata        = sub_res;

    // mix write-back, in the cycle after the read issue
    if (wr_pend_q) begin
      mem_we = 1'b1;
    end

    case (state_q)
      sld_pkg::ST_IDLE: begin
        if (in_xfer) begin
          data_d = data_byte_i;
          if (cur_phase == PHASE_LAST) begin
            phase_d   = '0;
            key_idx_d = cur_key + 4'd1;
          end else begin
            phase_d   = cur_phase + PHASE_W'(1);
            key_idx_d = cur_key;
          end
          if (cur_phase == '0) begin
            // reseed: top entry takes the seed, fill walks from slot 21
            mem_we     = 1'b1;
            waddr      = sld_pkg::LAG_LEN;
            wdata      = VW'(seed);
            prev_d     = VW'(1);
            cur_d      = VW'(seed);
            slot_d     = sld_pkg::FILL_STEP;
            fill_cnt_d = '0;
            state_d    = sld_pkg::ST_FILL;
          end else if (read_index_q == sld_pkg::LAG_LEN) begin
            k_d          = AW'(1);
            passes_d     = 3'd1;
            read_index_d = '0;
            state_d      = sld_pkg::ST_MIX;
          end else begin
            state_d = sld_pkg::ST_KEY_RD;
          end
        end
      end

      sld_pkg::ST_FILL: begin
        sub_a      = cur_q;
        sub_b      = prev_q;
        mem_we     = 1'b1;
        waddr      = slot_q;
        wdata      = prev_q;
        cur_d      = prev_q;
        prev_d     = sub_res;
        slot_d     = (slot_sum >= {1'b0, sld_pkg::LAG_LEN})
                     ? AW'(slot_sum - {1'b0, sld_pkg::LAG_LEN}) : AW'(slot_sum);
        fill_cnt_d = fill_cnt_q + AW'(1);
        if (fill_cnt_q == sld_pkg::FILL_STEPS - AW'(1)) begin
          // four reseed mix passes over the refilled table
          k_d          = AW'(1);
          passes_d     = sld_pkg::RESEED_PASSES;
          read_index_d = '0;
          state_d      = sld_pkg::ST_MIX;
        end
      end

      sld_pkg::ST_MIX: begin
        raddr_a   = k_q;
        raddr_b   = partner;
        wr_pend_d = 1'b1;
        wr_addr_d = k_q;
        if (k_q == sld_pkg::LAG_LEN) begin
          k_d = AW'(1);
          if (passes_q == 3'd1) begin
            state_d = sld_pkg::ST_KEY_RD;
          end else begin
            passes_d = passes_q - 3'd1;
          end
        end else begin
          k_d = k_q + AW'(1);
        end
      end

      sld_pkg::ST_KEY_RD: begin
        raddr_a      = read_index_q + AW'(1);
        read_index_d = read_index_q + AW'(1);
        state_d      = sld_pkg::ST_DELIVER;
      end

      sld_pkg::ST_DELIVER: begin
        // read address held so the keystream entry stays in rd_a_q
        raddr_a = read_index_q;
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = direction_q ? (data_q + ks) : (data_q - ks);
          state_d     = sld_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = sld_pkg::ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= sld_pkg::ST_IDLE;
      phase_q      <= '0;
      key_idx_q    <= '0;
      read_index_q <= sld_pkg::LAG_LEN;
      fill_cnt_q   <= '0;
      k_q          <= AW'(1);
      passes_q     <= '0;
      wr_pend_q    <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      phase_q      <= phase_d;
      key_idx_q    <= key_idx_d;
      read_index_q <= read_index_d;
      fill_cnt_q   <= fill_cnt_d;
      k_q          <= k_d;
      passes_q     <= passes_d;
      wr_pend_q    <= wr_pend_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // configuration registers, unknown indexes ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_word0_q <= sld_pkg::KEY_WORD0_RST;
      key_word1_q <= sld_pkg::KEY_WORD1_RST;
      key_word2_q <= sld_pkg::KEY_WORD2_RST;
      key_word3_q <= sld_pkg::KEY_WORD3_RST;
      direction_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        sld_pkg::CFG_KEY_WORD0: key_word0_q <= cfg_data_i;
        sld_pkg::CFG_KEY_WORD1: key_word1_q <= cfg_data_i;
        sld_pkg::CFG_KEY_WORD2: key_word2_q <= cfg_data_i;
        sld_pkg::CFG_KEY_WORD3: key_word3_q <= cfg_data_i;
        sld_pkg::CFG_DIRECTION: direction_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    data_q     <= data_d;
    slot_q     <= slot_d;
    prev_q     <= prev_d;
    cur_q      <= cur_d;
    wr_addr_q  <= wr_addr_d;
    out_data_q <= out_data_d;
  end

  // lag table: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      lag_mem[waddr] <= wdata;
    end
    rd_a_q <= lag_mem[raddr_a];
    rd_b_q <= lag_mem[raddr_b];
  end

endmodule

[rtl/sld_checker.sv]
// ----------------------------------------------------------------------------
// sld_checker: port-level checks for the lagged-Fibonacci descrambler
// output handshake, busy time after a transfer and result accounting
// ----------------------------------------------------------------------------
module sld_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] result_byte_o
);

  logic       in_xfer, out_xfer;
  logic [1:0] pend_q;

  assign in_xfer  = in_valid_i && in_ready_o;
  assign out_xfer = out_valid_o && out_ready_i;

  // bytes taken in but not yet handed out
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 2'd0;
    end else begin
      pend_q <= pend_q + 2'(in_xfer) - 2'(out_xfer);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped before transfer");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(result_byte_o))
    else $error("result changed while stalled");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !in_ready_o ##1 !in_ready_o)
    else $error("next byte taken too early");

  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pend_q != 2'd0))
    else $error("result without a pending byte");

endmodule

bind subtractive_lfg_byte_descrambler sld_checker u_sld_checker (.*);
